// ----- hdl/ervt_pkg.sv -----
`timescale 1ns / 1ps

package ervt_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_VEC_WIDTH      = 16;
  localparam int DEF_COEF_FRAC_BITS = 14;
  localparam int DEF_ANGLE_BITS     = 16;

  // Configuration port geometry and register map.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_YAW   = 2'd0;
  localparam logic [1:0] REG_PITCH = 2'd1;
  localparam logic [1:0] REG_ROLL  = 2'd2;

  // Sine/cosine unit: 32-bit phase, Q2.30 results.
  localparam int PHASE_W       = 32;
  localparam int TRIG_W        = 32;
  localparam int TRIG_FRAC     = 30;
  localparam int ANGLE_ACC_W   = PHASE_W + 1;
  localparam int CORDIC_STEPS  = 30;
  localparam int CORDIC_STEP_W = $clog2(CORDIC_STEPS);
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // Arctangent of 2^-i as a fraction of a full turn, 32-bit phase units.
  localparam logic [PHASE_W-1:0] ARCTAN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // Request to and answer from the sine/cosine unit.
  typedef struct packed {
    logic               start;
    logic [PHASE_W-1:0] phase;
  } cordic_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } cordic_rsp_t;

endpackage

// ----- hdl/ervt_vec_if.sv -----
`timescale 1ns / 1ps

interface ervt_vec_if #(
  parameter int VEC_WIDTH = ervt_pkg::DEF_VEC_WIDTH
);
  logic                        valid;
  logic                        ready;
  logic signed [VEC_WIDTH-1:0] vec_x;
  logic signed [VEC_WIDTH-1:0] vec_y;
  logic signed [VEC_WIDTH-1:0] vec_z;

  modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

// ----- hdl/ervt_rot_if.sv -----
`timescale 1ns / 1ps

interface ervt_rot_if #(
  parameter int VEC_WIDTH = ervt_pkg::DEF_VEC_WIDTH
);
  logic                      valid;
  logic                      ready;
  logic signed [VEC_WIDTH:0] rot_x;
  logic signed [VEC_WIDTH:0] rot_y;
  logic signed [VEC_WIDTH:0] rot_z;

  modport source (output valid, output rot_x, output rot_y, output rot_z, input ready);
  modport sink   (input valid, input rot_x, input rot_y, input rot_z, output ready);
endinterface

// ----- hdl/ervt_cordic.sv -----
`timescale 1ns / 1ps

module ervt_cordic (
  input  logic                  clk,
  input  logic                  rst,
  input  ervt_pkg::cordic_req_t req,
  output ervt_pkg::cordic_rsp_t rsp
);
  import ervt_pkg::*;

  localparam logic [CORDIC_STEP_W-1:0] LAST_STEP = CORDIC_STEP_W'(CORDIC_STEPS - 1);

  logic                          running;
  logic                          done;
  logic [CORDIC_STEP_W-1:0]      step;
  logic signed [TRIG_W-1:0]      x;
  logic signed [TRIG_W-1:0]      y;
  logic signed [ANGLE_ACC_W-1:0] z;
  logic                          neg;

  logic                          fold;
  logic [PHASE_W-1:0]            phase_f;
  logic signed [TRIG_W-1:0]      dx;
  logic signed [TRIG_W-1:0]      dy;
  logic signed [ANGLE_ACC_W-1:0] atan;

  // Phases in the left half-plane are turned by half a turn; results negated later.
  assign fold    = req.phase[PHASE_W-1] ^ req.phase[PHASE_W-2];
  assign phase_f = {req.phase[PHASE_W-1] ^ fold, req.phase[PHASE_W-2:0]};

  // One rotation step: arithmetic shifts floor toward minus infinity.
  assign dx   = y >>> step;
  assign dy   = x >>> step;
  assign atan = $signed({1'b0, ARCTAN[step]});

  // Step sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else if (req.start) begin
      running <= 1'b1;
      done    <= 1'b0;
      step    <= '0;
    end else if (running) begin
      if (step == LAST_STEP) begin
        running <= 1'b0;
        done    <= 1'b1;
      end else begin
        step <= step + 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Rotation datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      x   <= CORDIC_GAIN;
      y   <= '0;
      z   <= ANGLE_ACC_W'($signed(phase_f));
      neg <= fold;
    end else if (running) begin
      if (!z[ANGLE_ACC_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan;
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.cos_v = neg ? -x : x;
  assign rsp.sin_v = neg ? -y : y;

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    req.start |=> (running && step == '0 && !rsp.done))
    else $error("sine/cosine unit did not begin a fresh rotation after start");

endmodule

// ----- hdl/ervt_coef_gen.sv -----
`timescale 1ns / 1ps

module ervt_coef_gen #(
  parameter int COEF_FRAC_BITS = ervt_pkg::DEF_COEF_FRAC_BITS,
  parameter int ANGLE_BITS     = ervt_pkg::DEF_ANGLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ANGLE_BITS-1:0]          yaw,
  input  logic [ANGLE_BITS-1:0]          pitch,
  input  logic [ANGLE_BITS-1:0]          roll,
  output logic                           busy,
  output logic signed [COEF_FRAC_BITS+1:0] coef [9]
);
  import ervt_pkg::*;

  localparam int CW        = COEF_FRAC_BITS + 2;
  localparam int PROD_W    = 2 * TRIG_W;
  localparam int RND_W     = PROD_W + 1;
  localparam int CO_SHIFT  = 2 * TRIG_FRAC - COEF_FRAC_BITS;
  localparam int MOP_COUNT = 15;
  localparam int MOP_W     = $clog2(MOP_COUNT);
  localparam logic [MOP_W-1:0] LAST_MOP = MOP_W'(MOP_COUNT - 1);

  localparam logic signed [RND_W-1:0] CO_HALF   = RND_W'(1) << (CO_SHIFT - 1);
  localparam logic signed [RND_W-1:0] CO_LIM    = RND_W'(1) << COEF_FRAC_BITS;
  localparam logic signed [RND_W-1:0] CO_LIM_N  = -CO_LIM;
  localparam logic signed [RND_W-1:0] TRIG_HALF = RND_W'(1) << (TRIG_FRAC - 1);
  localparam logic signed [TRIG_W-1:0] MINUS_ONE_Q30 = -(TRIG_W'(1) << TRIG_FRAC);
  localparam logic signed [CW-1:0] COEF_ONE = CW'(1) << COEF_FRAC_BITS;

  // Destinations beyond the nine coefficients hold the two shared products.
  localparam logic [3:0] DEST_SBSG = 4'd9;
  localparam logic [3:0] DEST_SBCG = 4'd10;

  typedef enum logic [1:0] {S_IDLE, S_TRIG, S_MAT, S_DRAIN} state_t;
  typedef enum logic [3:0] {
    OPD_CG, OPD_SG, OPD_CB, OPD_SB, OPD_CA, OPD_SA, OPD_SBSG, OPD_SBCG, OPD_M1
  } opd_t;
  typedef enum logic [1:0] {K_LOAD, K_SINGLE, K_ADD, K_SUB} kind_t;
  typedef struct packed {
    opd_t       a;
    opd_t       b;
    kind_t      kind;
    logic [3:0] dest;
  } mop_t;

  // Product sequence: shared products first, so they are stored before use.
  function automatic mop_t mop_of(input logic [MOP_W-1:0] s);
    mop_t m;
    m = '{a: OPD_CG, b: OPD_CG, kind: K_LOAD, dest: 4'd0};
    case (s)
      4'd0:    m = '{a: OPD_SB, b: OPD_SG,   kind: K_SINGLE, dest: DEST_SBSG};
      4'd1:    m = '{a: OPD_SB, b: OPD_CG,   kind: K_SINGLE, dest: DEST_SBCG};
      4'd2:    m = '{a: OPD_CA, b: OPD_CB,   kind: K_SINGLE, dest: 4'd0};
      4'd3:    m = '{a: OPD_SA, b: OPD_CB,   kind: K_SINGLE, dest: 4'd3};
      4'd4:    m = '{a: OPD_SB, b: OPD_M1,   kind: K_SINGLE, dest: 4'd6};
      4'd5:    m = '{a: OPD_CB, b: OPD_SG,   kind: K_SINGLE, dest: 4'd7};
      4'd6:    m = '{a: OPD_CB, b: OPD_CG,   kind: K_SINGLE, dest: 4'd8};
      4'd7:    m = '{a: OPD_CA, b: OPD_SBSG, kind: K_LOAD,   dest: 4'd0};
      4'd8:    m = '{a: OPD_SA, b: OPD_CG,   kind: K_SUB,    dest: 4'd1};
      4'd9:    m = '{a: OPD_CA, b: OPD_SBCG, kind: K_LOAD,   dest: 4'd0};
      4'd10:   m = '{a: OPD_SA, b: OPD_SG,   kind: K_ADD,    dest: 4'd2};
      4'd11:   m = '{a: OPD_SA, b: OPD_SBSG, kind: K_LOAD,   dest: 4'd0};
      4'd12:   m = '{a: OPD_CA, b: OPD_CG,   kind: K_ADD,    dest: 4'd4};
      4'd13:   m = '{a: OPD_SA, b: OPD_SBCG, kind: K_LOAD,   dest: 4'd0};
      4'd14:   m = '{a: OPD_CA, b: OPD_SG,   kind: K_SUB,    dest: 4'd5};
      default: m = '{a: OPD_CG, b: OPD_CG,   kind: K_LOAD,   dest: 4'd0};
    endcase
    return m;
  endfunction

  state_t                   st;
  logic [1:0]               ang;
  logic [MOP_W-1:0]         step;
  logic                     drain;

  logic signed [TRIG_W-1:0] trig_c [3];
  logic signed [TRIG_W-1:0] trig_s [3];
  logic signed [TRIG_W-1:0] sbsg;
  logic signed [TRIG_W-1:0] sbcg;

  cordic_req_t              req;
  cordic_rsp_t              rsp;
  logic [PHASE_W-1:0]       ph_yaw;
  logic [PHASE_W-1:0]       ph_pitch;
  logic [PHASE_W-1:0]       ph_roll;
  logic                     trig_wr;

  mop_t                     mop;
  logic                     issue;
  logic signed [TRIG_W-1:0] mul_a;
  logic signed [TRIG_W-1:0] mul_b;

  logic signed [PROD_W-1:0] prod;
  logic                     c1_valid;
  kind_t                    c1_kind;
  logic [3:0]               c1_dest;
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] res;
  logic                     c2_valid;
  logic [3:0]               c2_dest;

  logic signed [RND_W-1:0]  co_sum;
  logic signed [RND_W-1:0]  co_q;
  logic signed [RND_W-1:0]  co_clamp;
  logic signed [RND_W-1:0]  tr_sum;
  logic signed [RND_W-1:0]  tr_q;

  // Angles as 32-bit phases.
  assign ph_yaw   = {yaw,   {(PHASE_W - ANGLE_BITS){1'b0}}};
  assign ph_pitch = {pitch, {(PHASE_W - ANGLE_BITS){1'b0}}};
  assign ph_roll  = {roll,  {(PHASE_W - ANGLE_BITS){1'b0}}};

  // The three angles go through the sine/cosine unit one after another.
  assign trig_wr   = (st == S_TRIG) && rsp.done && !start;
  assign req.start = start || (trig_wr && ang != REG_ROLL);
  assign req.phase = start ? ph_yaw : ((ang == REG_YAW) ? ph_pitch : ph_roll);

  ervt_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign busy = (st != S_IDLE) || start;

  // Sequencer: angles, then the product sequence, then the pipeline drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      ang   <= '0;
      step  <= '0;
      drain <= 1'b0;
    end else if (start) begin
      st  <= S_TRIG;
      ang <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
        end
        S_TRIG: begin
          if (rsp.done) begin
            if (ang == REG_ROLL) begin
              st   <= S_MAT;
              step <= '0;
            end else begin
              ang <= ang + 1'b1;
            end
          end
        end
        S_MAT: begin
          if (step == LAST_MOP) begin
            st    <= S_DRAIN;
            drain <= 1'b0;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DRAIN: begin
          if (drain) begin
            st <= S_IDLE;
          end else begin
            drain <= 1'b1;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Sines and cosines: index 0 yaw, 1 pitch, 2 roll.
  always_ff @(posedge clk) begin
    if (trig_wr) begin
      trig_c[ang] <= rsp.cos_v;
      trig_s[ang] <= rsp.sin_v;
    end
  end

  // Operand selection for the shared multiplier.
  function automatic logic signed [TRIG_W-1:0] opd_val(input opd_t o);
    logic signed [TRIG_W-1:0] v;
    v = '0;
    case (o)
      OPD_CG:   v = trig_c[0];
      OPD_SG:   v = trig_s[0];
      OPD_CB:   v = trig_c[1];
      OPD_SB:   v = trig_s[1];
      OPD_CA:   v = trig_c[2];
      OPD_SA:   v = trig_s[2];
      OPD_SBSG: v = sbsg;
      OPD_SBCG: v = sbcg;
      OPD_M1:   v = MINUS_ONE_Q30;
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign mop   = mop_of(step);
  assign issue = (st == S_MAT) && !start;

  // The operands follow both the step and the stored sines and cosines.
  always_comb begin
    mul_a = opd_val(mop.a);
    mul_b = opd_val(mop.b);
  end

  // Stage one: the product.
  always_ff @(posedge clk) begin
    prod    <= PROD_W'(mul_a) * PROD_W'(mul_b);
    c1_kind <= mop.kind;
    c1_dest <= mop.dest;
  end

  // Stage two: combine with the held product of the row term.
  always_ff @(posedge clk) begin
    if (c1_valid) begin
      case (c1_kind)
        K_LOAD:   acc <= prod;
        K_SINGLE: res <= prod;
        K_ADD:    res <= acc + prod;
        K_SUB:    res <= acc - prod;
        default:  res <= prod;
      endcase
    end
    c2_dest <= c1_dest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
      c2_valid <= 1'b0;
    end else begin
      c1_valid <= issue;
      c2_valid <= c1_valid && (c1_kind != K_LOAD);
    end
  end

  // Stage three: round to nearest, clamp and store.
  always_comb begin
    co_sum = RND_W'(res) + CO_HALF;
    co_q   = co_sum >>> CO_SHIFT;
    if (co_q > CO_LIM) begin
      co_clamp = CO_LIM;
    end else if (co_q < CO_LIM_N) begin
      co_clamp = CO_LIM_N;
    end else begin
      co_clamp = co_q;
    end
    tr_sum = RND_W'(res) + TRIG_HALF;
    tr_q   = tr_sum >>> TRIG_FRAC;
  end

  always_ff @(posedge clk) begin
    if (c2_valid && c2_dest == DEST_SBSG) begin
      sbsg <= tr_q[TRIG_W-1:0];
    end
    if (c2_valid && c2_dest == DEST_SBCG) begin
      sbcg <= tr_q[TRIG_W-1:0];
    end
  end

  // Coefficients reset to the identity matrix.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        coef[k] <= (k == 0 || k == 4 || k == 8) ? COEF_ONE : '0;
      end
    end else begin
      for (int k = 0; k < 9; k++) begin
        if (c2_valid && c2_dest == 4'(k)) begin
          coef[k] <= co_clamp[CW-1:0];
        end
      end
    end
  end

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    start |=> (st == S_TRIG && ang == 2'd0))
    else $error("rebuild did not restart from the first angle");

  a_store_busy: assert property (@(posedge clk) disable iff (rst)
    c2_valid |-> busy)
    else $error("coefficient store written while the block reports idle");

endmodule

// ----- hdl/ervt_mat_pipe.sv -----
`timescale 1ns / 1ps

module ervt_mat_pipe #(
  parameter int VEC_WIDTH      = ervt_pkg::DEF_VEC_WIDTH,
  parameter int COEF_FRAC_BITS = ervt_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             hold,
  input  logic signed [COEF_FRAC_BITS+1:0] coef [9],
  ervt_vec_if.sink                         vec,
  ervt_rot_if.source                       rot
);
  import ervt_pkg::*;

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int PW = CW + VEC_WIDTH;
  localparam int SW = PW + 2;
  localparam int RW = SW + 1;
  localparam int OW = VEC_WIDTH + 1;

  localparam logic signed [RW-1:0] ROUND_HALF = RW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [RW-1:0] OUT_HI = {{(RW - VEC_WIDTH){1'b0}}, {VEC_WIDTH{1'b1}}};
  localparam logic signed [RW-1:0] OUT_LO = {{(RW - VEC_WIDTH){1'b1}}, {VEC_WIDTH{1'b0}}};

  logic                        v1, v2, v3;
  logic                        en1, en2, en3;
  logic                        in_fire;
  logic signed [VEC_WIDTH-1:0] vin [3];
  logic signed [PW-1:0]        prod [3][3];
  logic signed [SW-1:0]        row_sum [3];
  logic signed [RW-1:0]        rnd_sum [3];
  logic signed [RW-1:0]        rnd_q [3];
  logic signed [OW-1:0]        sat [3];
  logic signed [OW-1:0]        res [3];

  // A stage loads when it is empty or its content moves on.
  assign en3     = !v3 || rot.ready;
  assign en2     = !v2 || en3;
  assign en1     = !v1 || en2;
  assign vec.ready = en1 && !hold;
  assign in_fire = vec.valid && vec.ready;

  assign vin[0] = vec.vec_x;
  assign vin[1] = vec.vec_y;
  assign vin[2] = vec.vec_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_fire;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Stage one: the nine products.
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= PW'(coef[3*i+j]) * PW'(vin[j]);
        end
      end
    end
  end

  // Stage two: row sums.
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        row_sum[i] <= SW'(prod[i][0]) + SW'(prod[i][1]) + SW'(prod[i][2]);
      end
    end
  end

  // Stage three: round to nearest, saturate, hold for the output transfer.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_sum[i] = RW'(row_sum[i]) + ROUND_HALF;
      rnd_q[i]   = rnd_sum[i] >>> COEF_FRAC_BITS;
      if (rnd_q[i] > OUT_HI) begin
        sat[i] = OUT_HI[OW-1:0];
      end else if (rnd_q[i] < OUT_LO) begin
        sat[i] = OUT_LO[OW-1:0];
      end else begin
        sat[i] = rnd_q[i][OW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        res[i] <= sat[i];
      end
    end
  end

  assign rot.valid = v3;
  assign rot.rot_x = res[0];
  assign rot.rot_y = res[1];
  assign rot.rot_z = res[2];

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> v1)
    else $error("accepted vector did not enter the first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && !rot.ready) |-> !vec.ready)
    else $error("full pipeline still accepting a vector");

endmodule

// ----- hdl/euler_rotation_vector_transform.sv -----
`timescale 1ns / 1ps

// Rotates a stream of signed 3-vectors by R = Rz(roll) * Ry(pitch) * Rx(yaw), with each
// component rounded to nearest after the fixed-point product. Once the matrix is built the
// block takes one vector per clock cycle while rot.ready is high, and each result is
// registered through the three-stage multiply, sum and round pipeline, which carries valid
// bits and holds under back-pressure. Writing any angle register (byte addresses 0, 4 and 8)
// rebuilds the nine coefficients: the angles pass one by one through an iterative
// sine/cosine unit of 30 steps, then a sequence of fifteen products on one shared 32 x 32
// multiplier forms the matrix. vec.ready is held low while this runs; reads of the
// registers are served at all times.
module euler_rotation_vector_transform #(
  parameter int VEC_WIDTH      = ervt_pkg::DEF_VEC_WIDTH,
  parameter int COEF_FRAC_BITS = ervt_pkg::DEF_COEF_FRAC_BITS,
  parameter int ANGLE_BITS     = ervt_pkg::DEF_ANGLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  ervt_vec_if.sink                        vec,
  ervt_rot_if.source                      rot,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ervt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ervt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ervt_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import ervt_pkg::*;

  logic [ANGLE_BITS-1:0]        yaw;
  logic [ANGLE_BITS-1:0]        pitch;
  logic [ANGLE_BITS-1:0]        roll;
  logic                         rebuild_req;
  logic                         wr_fire;
  logic [1:0]                   reg_idx;
  logic                         busy;
  logic signed [COEF_FRAC_BITS+1:0] coef [9];

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  // Angle registers; a write starts a rebuild in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw         <= '0;
      pitch       <= '0;
      roll        <= '0;
      rebuild_req <= 1'b0;
    end else begin
      rebuild_req <= 1'b0;
      if (wr_fire) begin
        unique case (reg_idx)
          REG_YAW: begin
            yaw         <= pwdata[ANGLE_BITS-1:0];
            rebuild_req <= 1'b1;
          end
          REG_PITCH: begin
            pitch       <= pwdata[ANGLE_BITS-1:0];
            rebuild_req <= 1'b1;
          end
          REG_ROLL: begin
            roll        <= pwdata[ANGLE_BITS-1:0];
            rebuild_req <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_YAW:   prdata = APB_DATA_W'(yaw);
      REG_PITCH: prdata = APB_DATA_W'(pitch);
      REG_ROLL:  prdata = APB_DATA_W'(roll);
      default:   prdata = '0;
    endcase
  end

  ervt_coef_gen #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .ANGLE_BITS     (ANGLE_BITS)
  ) u_coef_gen (
    .clk   (clk),
    .rst   (rst),
    .start (rebuild_req),
    .yaw   (yaw),
    .pitch (pitch),
    .roll  (roll),
    .busy  (busy),
    .coef  (coef)
  );

  ervt_mat_pipe #(
    .VEC_WIDTH      (VEC_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mat_pipe (
    .clk  (clk),
    .rst  (rst),
    .hold (busy),
    .coef (coef),
    .vec  (vec),
    .rot  (rot)
  );

endmodule
